// File: src/qpd_pkg.sv
// Package: shared types and constants for the quantized point dedup block.
`default_nettype none

package qpd_pkg;

   // One longitude period: 360 degrees scaled by 2^21.
   localparam int unsigned LON_W = 30;
   localparam logic [LON_W-1:0] LON_PERIOD = 30'd754974720;

   // Bias of three periods makes any signed 32-bit longitude non-negative.
   localparam int unsigned BIAS_W = 33;
   localparam logic [BIAS_W-1:0] LON_BIAS = 33'd2264924160;

   localparam int unsigned LAT_W   = 32;
   localparam int unsigned KEY_W   = LON_W + LAT_W;
   localparam int unsigned ID_W    = 10;
   localparam int unsigned UCNT_W  = 11;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;
      logic wrap_step;
      logic search_start;
      logic search_step;
      logic commit;
   } qpd_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic wrap_done;
      logic hit;
      logic miss;
   } qpd_status_type;

endpackage

`default_nettype wire

// File: src/qpd_if.sv
// Interfaces: request and response channels of the quantized point dedup block.
`default_nettype none

interface qpd_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] lon_fixed;
   logic signed [31:0] lat_fixed;
   logic               last_point;

   modport source (output valid, output lon_fixed, output lat_fixed, output last_point,
                   input ready);
   modport sink (input valid, input lon_fixed, input lat_fixed, input last_point,
                 output ready);
endinterface

interface qpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  new_id;
   logic        is_new;
   logic [29:0] wrapped_lon;
   logic [10:0] unique_count;
   logic        overflow;

   modport source (output valid, output new_id, output is_new, output wrapped_lon,
                   output unique_count, output overflow, input ready);
   modport sink (input valid, input new_id, input is_new, input wrapped_lon,
                 input unique_count, input overflow, output ready);
endinterface

`default_nettype wire

// File: src/quantized_point_dedup.sv
// Sequence: capture, then w period subtractions (0 to 5) for the longitude wrap, then a
// search of the n keys stored in the current set.
// A hit on entry k ends the search early.
// Flow: one word at a time; the next request word is taken in the cycle after the
// response word leaves. The search is bound by the single read port of the key table,
// which it walks one entry per cycle.
// Reset: synchronous, active high; empties the set, key table contents are left as is.
`default_nettype none

module quantized_point_dedup
   import qpd_pkg::*;
#(
   parameter int unsigned MAX_POINTS = 1024
) (
   input wire logic  clock,
   input wire logic  reset,
   qpd_req_if.sink   req_bus,
   qpd_rsp_if.source rsp_bus
);

   qpd_cmd_type    cmd;
   qpd_status_type status;

   // Sequence each word: capture, wrap, scan stored keys, then hold the result
   // until the response side takes it.
   qpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Wrap the longitude into (0, period], search the table, insert new keys
   // and register the response word.
   qpd_dpath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .lon_fixed    (req_bus.lon_fixed),
      .lat_fixed    (req_bus.lat_fixed),
      .last_point   (req_bus.last_point),
      .new_id       (rsp_bus.new_id),
      .is_new       (rsp_bus.is_new),
      .wrapped_lon  (rsp_bus.wrapped_lon),
      .unique_count (rsp_bus.unique_count),
      .overflow     (rsp_bus.overflow)
   );

endmodule

`default_nettype wire

// File: src/qpd_ctrl.sv
// Controller: state machine that sequences wrap, table search and response.
`default_nettype none

module qpd_ctrl
   import qpd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output      logic           req_ready,
   output      logic           rsp_valid,
   input  wire logic           rsp_ready,
   output      qpd_cmd_type    cmd,
   input  wire qpd_status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_WRAP   = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_RESP   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            if (status.wrap_done) begin
               cmd.search_start = 1'b1;
               state_in         = ST_SEARCH;
            end else begin
               cmd.wrap_step = 1'b1;
            end
         end
         ST_SEARCH: begin
            if (status.hit || status.miss) begin
               cmd.commit = 1'b1;
               state_in   = ST_RESP;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: src/qpd_dpath.sv
// Datapath: longitude wrap, key table memory, sequential search and result registers.
`default_nettype none

module qpd_dpath
   import qpd_pkg::*;
#(
   parameter int unsigned MAX_POINTS = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire qpd_cmd_type        cmd,
   output      qpd_status_type     status,
   input  wire logic signed [31:0] lon_fixed,
   input  wire logic signed [31:0] lat_fixed,
   input  wire logic               last_point,
   output      logic [ID_W-1:0]    new_id,
   output      logic               is_new,
   output      logic [LON_W-1:0]   wrapped_lon,
   output      logic [UCNT_W-1:0]  unique_count,
   output      logic               overflow
);

   localparam int unsigned IDX_W = $clog2(MAX_POINTS);
   localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

   logic [KEY_W-1:0] key_mem [MAX_POINTS];

   logic [BIAS_W-1:0] lon_ff;
   logic [LAT_W-1:0]  lat_ff;
   logic              last_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff;
   logic              pend_ff;
   logic [IDX_W-1:0]  pend_idx_ff;
   logic [KEY_W-1:0]  rd_data_ff;

   logic [ID_W-1:0]   id_ff;
   logic              is_new_ff;
   logic [LON_W-1:0]  wlon_ff;
   logic [UCNT_W-1:0] ucnt_ff;
   logic              ovf_ff;

   logic [LON_W-1:0]  wlon;
   logic [KEY_W-1:0]  key;
   logic              full;
   logic [IDX_W-1:0]  id_sel;
   logic [IDX_W+ID_W-1:0]   id_ext;
   logic [CNT_W+UCNT_W-1:0] cnt_ext;

   // A zero remainder stands for a full period.
   assign wlon = (lon_ff == '0) ? LON_PERIOD : lon_ff[LON_W-1:0];
   assign key  = {wlon, lat_ff};
   assign full = (count_ff == CNT_MAX);

   assign status.wrap_done = (lon_ff < {{(BIAS_W-LON_W){1'b0}}, LON_PERIOD});
   assign status.hit       = pend_ff && (rd_data_ff == key);
   assign status.miss      = !pend_ff && (ptr_ff >= count_ff);

   always_comb begin
      count_in = count_ff;
      id_sel   = pend_idx_ff;
      if (!status.hit) begin
         id_sel = full ? '0 : count_ff[IDX_W-1:0];
         if (!full) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   assign id_ext  = {{ID_W{1'b0}}, id_sel};
   assign cnt_ext = {{UCNT_W{1'b0}}, count_in};

   // Operand capture and wrap by repeated period subtraction.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lon_ff  <= {lon_fixed[31], lon_fixed} + LON_BIAS;
         lat_ff  <= lat_fixed;
         last_ff <= last_point;
      end else if (cmd.wrap_step) begin
         lon_ff <= lon_ff - {{(BIAS_W-LON_W){1'b0}}, LON_PERIOD};
      end
   end

   // Scan pointer and read pipeline flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         pend_ff <= 1'b0;
      end else if (cmd.search_start) begin
         ptr_ff  <= '0;
         pend_ff <= 1'b0;
      end else if (cmd.search_step) begin
         if (ptr_ff < count_ff) begin
            ptr_ff  <= ptr_ff + CNT_W'(1);
            pend_ff <= 1'b1;
         end else begin
            pend_ff <= 1'b0;
         end
      end
   end

   // Key table: one read port for the scan, one write port for inserts.
   always_ff @(posedge clock) begin
      if (cmd.search_step && (ptr_ff < count_ff)) begin
         rd_data_ff  <= key_mem[ptr_ff[IDX_W-1:0]];
         pend_idx_ff <= ptr_ff[IDX_W-1:0];
      end
      if (cmd.commit && !status.hit && !full) begin
         key_mem[count_ff[IDX_W-1:0]] <= key;
      end
   end

   // Stored key count; empty the set after its last point.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= last_ff ? '0 : count_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         id_ff     <= id_ext[ID_W-1:0];
         is_new_ff <= !status.hit && !full;
         ovf_ff    <= !status.hit && full;
         wlon_ff   <= wlon;
         ucnt_ff   <= cnt_ext[UCNT_W-1:0];
      end
   end

   assign new_id       = id_ff;
   assign is_new       = is_new_ff;
   assign wrapped_lon  = wlon_ff;
   assign unique_count = ucnt_ff;
   assign overflow     = ovf_ff;

endmodule

`default_nettype wire

// File: test/quantized_point_dedup_tb.sv
// Testbench: checks quantized_point_dedup words against a key-table predictor.
`default_nettype none

module quantized_point_dedup_tb;
   import qpd_pkg::*;

   localparam int unsigned MAX_POINTS   = 1024;
   localparam int unsigned RANDOM_ITEMS = 563;
   // Run the tail of the random part with both sides streaming.
   localparam int unsigned QUIET_ITEMS  = 80;
   // Allow the longest search plus the wrap and pipeline cycles.
   localparam int unsigned DRAIN_CYCLES = MAX_POINTS + 64;
   // Worst case: ~580 words, each a full-table search plus stall and gap, many times over.
   localparam longint CYCLE_LIMIT = 64'd8000000;
   localparam longint PERIOD = longint'(LON_PERIOD);
   localparam logic signed [31:0] P1 = 32'sd754974720;
   localparam logic signed [31:0] P2 = 32'sd1509949440;
   localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
   localparam int unsigned MAX_REPORTS = 40;

   // One response word as the predictor sees it.
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic              is_new;
      logic [LON_W-1:0]  wlon;
      logic [UCNT_W-1:0] ucount;
      logic              ovf;
   } dedup_word_type;

   // Mirror of the key table: predicts each response word and checks the block's words.
   class dedup_tracker;
      logic [KEY_W-1:0] key_table [MAX_POINTS];
      int unsigned      stored;
      dedup_word_type   due_words [$];
      int unsigned      mismatches;
      int unsigned      checked;
      int unsigned      new_keys;
      int unsigned      repeats;
      int unsigned      overflows;
      int unsigned      sets;

      function new();
         stored     = 0;
         mismatches = 0;
         checked    = 0;
         new_keys   = 0;
         repeats    = 0;
         overflows  = 0;
         sets       = 0;
      endfunction

      // Predict the word for an accepted point and queue it.
      function void accept_point(logic signed [31:0] lon, logic [31:0] lat, logic last);
         longint           rem;
         logic [KEY_W-1:0] key;
         dedup_word_type   w;
         bit               found;
         int unsigned      idx;
         rem = longint'(lon) % PERIOD;
         if (rem < 0) rem += PERIOD;
         if (rem == 0) rem = PERIOD;
         w      = '0;
         w.wlon = LON_W'(rem);
         key    = {w.wlon, lat};
         found  = 1'b0;
         for (idx = 0; idx < stored && !found; idx++) begin
            if (key_table[idx] == key) begin
               found = 1'b1;
               w.id  = ID_W'(idx);
            end
         end
         if (!found) begin
            if (stored < MAX_POINTS) begin
               key_table[stored] = key;
               w.id     = ID_W'(stored);
               w.is_new = 1'b1;
               stored++;
            end else begin
               w.ovf = 1'b1;
            end
         end
         w.ucount = UCNT_W'(stored);
         if (last) begin
            stored = 0;
            sets++;
         end
         due_words.push_back(w);
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("MISMATCH word %0d: %s", checked, msg);
      endtask

      task check_word(dedup_word_type got);
         dedup_word_type want;
         if (due_words.size() == 0) begin
            report("response word with nothing expected");
         end else begin
            want = due_words.pop_front();
            if (got.id !== want.id)
               report($sformatf("new_id expected %0d got %0d", want.id, got.id));
            if (got.is_new !== want.is_new)
               report($sformatf("is_new expected %0d got %0d", want.is_new, got.is_new));
            if (got.wlon !== want.wlon)
               report($sformatf("wrapped_lon expected %0d got %0d", want.wlon, got.wlon));
            if (got.ucount !== want.ucount)
               report($sformatf("unique_count expected %0d got %0d", want.ucount, got.ucount));
            if (got.ovf !== want.ovf)
               report($sformatf("overflow expected %0d got %0d", want.ovf, got.ovf));
            if (want.is_new) new_keys++;
            else if (want.ovf) overflows++;
            else repeats++;
         end
         checked++;
      endtask

      function int unsigned pending();
         return due_words.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   qpd_req_if req_bus ();
   qpd_rsp_if rsp_bus ();

   quantized_point_dedup #(
      .MAX_POINTS(MAX_POINTS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   dedup_tracker tracker = new();

   bit             sender_idle   = 1'b1;
   bit             receiver_idle = 1'b1;
   int unsigned    stall_left    = 0;
   longint         cycles        = 0;
   dedup_word_type seen_word;

   // Free-running clock, period 2.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Drive every input to a known value from time zero.
   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.lon_fixed  = '0;
      req_bus.lat_fixed  = '0;
      req_bus.last_point = 1'b0;
      rsp_bus.ready      = 1'b0;
   end

   // Hang-up guard: give up after the cycle limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycles, tracker.pending());
         $display("quantized_point_dedup_tb: errors");
         $finish;
      end
   end

   // Response side: before the quiet tail, stall in random bursts; else take every word.
   always @(negedge clock) begin
      if (receiver_idle && stall_left == 0 && $urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 9);
      if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Sample response words at the rising edge and check them in order.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_word.id     = rsp_bus.new_id;
         seen_word.is_new = rsp_bus.is_new;
         seen_word.wlon   = rsp_bus.wrapped_lon;
         seen_word.ucount = rsp_bus.unique_count;
         seen_word.ovf    = rsp_bus.overflow;
         tracker.check_word(seen_word);
      end
   end

   // Longitude near a wrap point: multiples of the period, the 32-bit ends, small values.
   function automatic logic signed [31:0] corner_lon();
      longint base;
      case ($urandom_range(0, 8))
         0: base = 0;
         1: base = P1;
         2: base = -longint'(P1);
         3: base = P2;
         4: base = -longint'(P2);
         5: base = INT_MIN;
         6: base = INT_MAX;
         default: base = $urandom_range(0, 3);
      endcase
      base = base + longint'($urandom_range(0, 2)) - 1;
      return 32'(base);
   endfunction

   // Same wrapped longitude, different raw value: shift by one or two periods.
   function automatic logic signed [31:0] alias_lon(logic signed [31:0] lon);
      longint shift;
      longint v;
      shift = longint'($urandom_range(1, 2)) * PERIOD;
      v     = longint'(lon) + shift;
      if (v > longint'(INT_MAX)) v = longint'(lon) - shift;
      return 32'(v);
   endfunction

   // Present one word; entered and left just after a falling edge.
   task automatic send_point(input logic signed [31:0] lon, input logic [31:0] lat,
                             input logic last);
      if (sender_idle && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.lon_fixed  <= lon;
      req_bus.lat_fixed  <= lat;
      req_bus.last_point <= last;
      do @(posedge clock); while (!req_bus.ready);
      tracker.accept_point(lon, lat, last);
      @(negedge clock);
   endtask

   initial begin : stimulus
      logic signed [31:0] pool_lon [$];
      logic [31:0]        pool_lat [$];
      logic signed [31:0] lon;
      logic [31:0]        lat;
      int unsigned        k;
      int unsigned        j;
      int unsigned        set_size;
      int unsigned        random_sent;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: wrap corners, aliases of the same key, 32-bit ends, set boundaries.
      send_point(32'sd0, 32'd0, 1'b0);          // wraps to a full period
      send_point(P1, 32'd0, 1'b0);              // same key via P
      send_point(-P1, 32'd0, 1'b0);             // same key via -P
      send_point(P2, 32'd0, 1'b0);              // same key via 2P
      send_point(-P2, 32'd0, 1'b0);             // same key via -2P
      send_point(INT_MIN, 32'h8000_0000, 1'b0);
      send_point(INT_MAX, 32'h7FFF_FFFF, 1'b0);
      send_point(-32'sd1, 32'hFFFF_FFFF, 1'b0); // wraps to P-1
      send_point(32'sd1, 32'd1, 1'b0);
      send_point(P1 - 32'sd1, 32'hFFFF_FFFF, 1'b0); // repeat of -1 key
      send_point(P1 + 32'sd1, 32'd1, 1'b0);         // repeat of +1 key
      send_point(32'sd0, 32'd1, 1'b0);              // latitude alone differs
      send_point(32'sd0, 32'h8000_0000, 1'b0);
      send_point(INT_MIN, 32'h8000_0000, 1'b1);     // repeat that closes the set
      send_point(INT_MIN, 32'h8000_0000, 1'b0);     // table empty again: id 0
      send_point(32'sd5, 32'd7, 1'b1);
      send_point(32'sd123, -32'sd123, 1'b1);        // one-point set

      // Random sets: mostly short, a few long; many repeats and near misses per set.
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 24);
         if (set_size > RANDOM_ITEMS - random_sent) set_size = RANDOM_ITEMS - random_sent;
         pool_lon.delete();
         pool_lat.delete();
         for (k = 0; k < set_size; k++) begin
            if (random_sent >= RANDOM_ITEMS - QUIET_ITEMS) begin
               sender_idle   = 1'b0;
               receiver_idle = 1'b0;
            end
            j = (pool_lon.size() == 0) ? 0 : $urandom_range(0, pool_lon.size() - 1);
            case ((pool_lon.size() == 0) ? 0 : $urandom_range(0, 9))
               0, 1, 9: begin
                  lon = $urandom;
                  lat = $urandom;
               end
               2: begin
                  lon = corner_lon();
                  case ($urandom_range(0, 4))
                     0: lat = 32'd0;
                     1: lat = 32'hFFFF_FFFF;
                     2: lat = 32'h8000_0000;
                     3: lat = 32'h7FFF_FFFF;
                     default: lat = $urandom;
                  endcase
               end
               3, 4, 5: begin
                  lon = pool_lon[j];
                  lat = pool_lat[j];
               end
               6: begin
                  lon = alias_lon(pool_lon[j]);
                  lat = pool_lat[j];
               end
               7: begin
                  lon = pool_lon[j];
                  lat = pool_lat[j] ^ (32'd1 << $urandom_range(0, 31));
               end
               default: begin
                  lon = pool_lon[j] ^ (32'sd1 << $urandom_range(0, 31));
                  lat = pool_lat[j];
               end
            endcase
            send_point(lon, lat, k == set_size - 1);
            pool_lon.push_back(lon);
            pool_lat.push_back(lat);
            random_sent++;
         end
      end
      req_bus.valid <= 1'b0;

      // Drain: wait for every expected word, then a full search time more.
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.pending() != 0)
         tracker.report($sformatf("%0d expected words never arrived", tracker.pending()));

      $display("checked %0d words in %0d sets: %0d new keys, %0d repeats, %0d overflows",
               tracker.checked, tracker.sets, tracker.new_keys, tracker.repeats,
               tracker.overflows);
      $display("mismatches: %0d", tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("quantized_point_dedup_tb: clean");
      end else begin
         $display("quantized_point_dedup_tb: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
